// ===== src/wtama_pkg.sv =====
// Shared types, constants and helpers of the weighted three-axis moving average.
package wtama_pkg;

	localparam int IN_W      = 16;
	localparam int VEL_W     = 25;
	localparam int SUM_W     = 33;
	localparam int PROD_W    = 33;
	localparam int QUO_W     = 24;
	localparam int DIV_STEPS = QUO_W / 2;
	localparam int AXES      = 3;

	typedef logic signed [IN_W-1:0]  sample_t;
	typedef logic signed [VEL_W-1:0] vel_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic [1:0]              axis_t;

	typedef enum logic [1:0] {
		REG_WEIGHT_X = 2'd0,
		REG_WEIGHT_Y = 2'd1,
		REG_WEIGHT_Z = 2'd2,
		REG_MAX_VEL  = 2'd3
	} cfg_reg_t;

	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Z = 2'd2;

	localparam sample_t     SAMPLE_MAX  = 16'sh7FFF;
	localparam sample_t     SAMPLE_MIN  = -16'sh8000;
	localparam logic [15:0] MAXV_RESET  = 16'd256;

	// Clamp a 17-bit signed value into Q1.15.
	function automatic sample_t sat16(input logic signed [16:0] s);
		sample_t r;
		if (s[16] != s[15]) begin
			r = s[16] ? SAMPLE_MIN : SAMPLE_MAX;
		end else begin
			r = s[15:0];
		end
		return r;
	endfunction

endpackage

// ===== src/wtama_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wtama_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/wtama_div.sv =====
// Radix-4 restoring divider: signed running sum over unsigned entry count.
module wtama_div #(
	parameter int DIV_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  wtama_pkg::sum_t   dividend,
	input  logic [DIV_W-1:0]  divisor,
	output logic              done,
	output wtama_pkg::vel_t   quotient
);
	import wtama_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] div_q;
	logic [QUO_W-1:0] dq_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;

	sum_t             mag;
	logic [SUM_W-1:0] mag_hi;
	logic [DIV_W:0]   d_ext;
	logic [DIV_W:0]   r1;
	logic [DIV_W:0]   r1s;
	logic [DIV_W:0]   r2;
	logic [DIV_W:0]   r2s;
	logic             ge1;
	logic             ge2;
	vel_t             q_pos;

	// The average fits in QUO_W bits, so the bits above are already below the divisor.
	assign mag    = dividend[SUM_W-1] ? -dividend : dividend;
	assign mag_hi = $unsigned(mag) >> QUO_W;

	// Two quotient bits per cycle.
	assign d_ext = {1'b0, div_q};
	assign r1    = {rem_q, dq_q[QUO_W-1]};
	assign ge1   = (r1 >= d_ext);
	assign r1s   = ge1 ? (r1 - d_ext) : r1;
	assign r2    = {r1s[DIV_W-1:0], dq_q[QUO_W-2]};
	assign ge2   = (r2 >= d_ext);
	assign r2s   = ge2 ? (r2 - d_ext) : r2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= mag_hi[DIV_W-1:0];
			dq_q  <= mag[QUO_W-1:0];
			div_q <= divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (busy_q) begin
			rem_q <= r2s[DIV_W-1:0];
			dq_q  <= {dq_q[QUO_W-3:0], ge1, ge2};
		end
	end

	// Truncate toward zero: divide magnitudes, then restore the sign.
	assign q_pos    = {1'b0, dq_q};
	assign quotient = neg_q ? -q_pos : q_pos;
	assign done     = done_q;

endmodule

// ===== src/weighted_three_axis_moving_average.sv =====
// Top level of the weighted three-axis moving average filter.
//
// Usage: write weights and velocity scale through wr_en/wr_index/wr_data while
// idle. Push one item (in_x, in_y, in_z) with in_valid; it is taken at an edge
// where in_valid is high and in_stall is low. Each item yields exactly one
// result (vel_x, vel_y, vel_z) on the output channel, taken at an edge where
// out_valid is high and out_stall is low.
// Sequence: in_stall stays high from acceptance until the result is loaded into
// the output register, so no new item is taken while one is in progress. Per
// axis one shared 17x17 multiplier runs a weight pass and a clamp-and-scale pass,
// then an accumulate step follows; the history row is then written, and one shared
// radix-4 divider forms the average of each axis in turn.
// Stall: the result sits in an output register; a new item is accepted while
// it waits. If the next result finishes while the previous one is still held,
// the block holds in its final state until the output register frees up.
// Reset: weights clear to zero, velocity scale to 1.0, running sums, slot and
// fill count to zero. The history RAM is not cleared; the fill count keeps
// unwritten entries out of the running sums.
module weighted_three_axis_moving_average #(
	parameter int DEPTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  wtama_pkg::cfg_reg_t   wr_index,
	input  logic [15:0]           wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  wtama_pkg::sample_t    in_x,
	input  wtama_pkg::sample_t    in_y,
	input  wtama_pkg::sample_t    in_z,
	output logic                  out_valid,
	input  logic                  out_stall,
	output wtama_pkg::vel_t       vel_x,
	output wtama_pkg::vel_t       vel_y,
	output wtama_pkg::vel_t       vel_z
);
	import wtama_pkg::*;

	localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ROW_W  = AXES * VEL_W;

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_MUL_W    = 8'b0000_0010,
		ST_MUL_V    = 8'b0000_0100,
		ST_ACC      = 8'b0000_1000,
		ST_WRITE    = 8'b0001_0000,
		ST_DIV      = 8'b0010_0000,
		ST_DIV_WAIT = 8'b0100_0000,
		ST_DONE     = 8'b1000_0000
	} state_t;

	// Configuration
	sample_t     wgt_q [AXES];
	logic [15:0] maxv_q;

	// Control
	state_t            state_q;
	axis_t             axis_q;
	sum_t              sum_q [AXES];
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  fill_q;
	logic              out_valid_q;

	// Payload
	sample_t                  in_q  [AXES];
	logic signed [PROD_W-1:0] prod_q;
	vel_t                     vel_q [AXES];
	vel_t                     res_q [AXES];
	vel_t                     vel_x_q;
	vel_t                     vel_y_q;
	vel_t                     vel_z_q;

	logic              accept;
	logic              full;
	logic              out_load;
	sample_t           sat_s;
	logic signed [16:0] op_a;
	logic signed [16:0] op_b;
	logic signed [33:0] mul_full;
	vel_t              v_new;
	vel_t              old_v;
	sum_t              old_ext;
	sum_t              sum_next;
	logic [ROW_W-1:0]  ram_rdata;
	logic [ROW_W-1:0]  ram_wdata;
	logic              ram_we;
	logic              div_start;
	logic              div_done;
	vel_t              div_quo;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign full     = (fill_q == CNT_W'(DEPTH));

	// Configuration writes; every index of the 2-bit port names a register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wgt_q[0] <= '0;
			wgt_q[1] <= '0;
			wgt_q[2] <= '0;
			maxv_q   <= MAXV_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WEIGHT_X: wgt_q[0] <= wr_data;
				REG_WEIGHT_Y: wgt_q[1] <= wr_data;
				REG_WEIGHT_Z: wgt_q[2] <= wr_data;
				REG_MAX_VEL:  maxv_q   <= wr_data;
				default:      maxv_q   <= maxv_q;
			endcase
		end
	end

	// Shared multiplier: first pass input*weight, second pass clamped*scale.
	assign sat_s = sat16($signed(prod_q[31:15]));

	always_comb begin
		if (state_q == ST_MUL_V) begin
			op_a = {sat_s[IN_W-1], sat_s};
			op_b = {1'b0, maxv_q};
		end else begin
			op_a = {in_q[axis_q][IN_W-1], in_q[axis_q]};
			op_b = {wgt_q[axis_q][IN_W-1], wgt_q[axis_q]};
		end
	end

	assign mul_full = op_a * op_b;

	// Q10.15 velocity is the scaled product shifted down by eight (floor).
	assign v_new    = prod_q[PROD_W-1:8];
	assign old_v    = ram_rdata[VEL_W*axis_q +: VEL_W];
	assign old_ext  = full ? SUM_W'(old_v) : '0;
	assign sum_next = sum_q[axis_q] + SUM_W'(v_new) - old_ext;

	// History ring: one row holds all three axes. Read the oldest row on accept.
	assign ram_we    = (state_q == ST_WRITE);
	assign ram_wdata = {vel_q[2], vel_q[1], vel_q[0]};

	wtama_ram #(
		.WIDTH (ROW_W),
		.DEPTH (DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	assign div_start = (state_q == ST_DIV);

	wtama_div #(
		.DIV_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q[axis_q]),
		.divisor  (fill_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Sequencer and running state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			axis_q   <= AXIS_X;
			sum_q[0] <= '0;
			sum_q[1] <= '0;
			sum_q[2] <= '0;
			slot_q   <= '0;
			fill_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						axis_q  <= AXIS_X;
						state_q <= ST_MUL_W;
					end
				end
				ST_MUL_W: begin
					state_q <= ST_MUL_V;
				end
				ST_MUL_V: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					// Drop the oldest entry once full, add the new one.
					sum_q[axis_q] <= sum_next;
					if (axis_q == AXIS_Z) begin
						axis_q  <= AXIS_X;
						state_q <= ST_WRITE;
					end else begin
						axis_q  <= axis_q + axis_t'(1);
						state_q <= ST_MUL_W;
					end
				end
				ST_WRITE: begin
					slot_q <= (slot_q == SLOT_W'(DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
					if (!full) begin
						fill_q <= fill_q + CNT_W'(1);
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						if (axis_q == AXIS_Z) begin
							state_q <= ST_DONE;
						end else begin
							axis_q  <= axis_q + axis_t'(1);
							state_q <= ST_DIV;
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; advance only in their own steps.
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q[0] <= in_x;
			in_q[1] <= in_y;
			in_q[2] <= in_z;
		end
		if (state_q == ST_MUL_W || state_q == ST_MUL_V) begin
			prod_q <= mul_full[PROD_W-1:0];
		end
		if (state_q == ST_ACC) begin
			vel_q[axis_q] <= v_new;
		end
		if (state_q == ST_DIV_WAIT && div_done) begin
			res_q[axis_q] <= div_quo;
		end
	end

	// Output register: load when empty or being taken this cycle.
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			vel_x_q <= res_q[0];
			vel_y_q <= res_q[1];
			vel_z_q <= res_q[2];
		end
	end

	assign out_valid = out_valid_q;
	assign vel_x     = vel_x_q;
	assign vel_y     = vel_y_q;
	assign vel_z     = vel_z_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count exceeds history depth");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_WAIT))
		else $error("divider finished outside of its wait step");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_MUL_W && axis_q == AXIS_X))
		else $error("accepted item did not start on the first axis");

	a_load_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && out_stall) |=> (state_q == ST_DONE))
		else $error("result left the sequencer while the output was held");

endmodule
